### hw/rtl/rfps_pkg.sv
// ---------------------------------------------------------------------------
// rfps_pkg - shared types and constants for the rarest-first piece selector
// Request codes, piece status codes, config indexes and the command/status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rfps_pkg;

    typedef enum logic [1:0] {
        REQ_SET_READY  = 2'd0,
        REQ_SET_HAVE   = 2'd1,
        REQ_SET_STATUS = 2'd2,
        REQ_QUERY      = 2'd3
    } t_req_type;

    localparam logic [1:0] ST_FREE = 2'd0;

    localparam logic CFG_TOTAL_PIECES = 1'b0;
    localparam logic CFG_PEERS_IN_USE = 1'b1;

    localparam logic [10:0] TOTAL_PIECES_RST = 11'd1024;
    localparam logic [4:0]  PEERS_IN_USE_RST = 5'd16;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // input word taken this cycle
        logic clr_wr;      // clearing pass write
        logic upd_wr;      // read-modify-write completion
        logic scan_issue;  // issue one scan read
        logic load_out;    // load result register
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic is_ram_upd;
        logic q_ok;        // query peer valid and pieces in use
        logic scan_last;
        logic clr_last;
        logic pipe_busy;
        logic out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

### hw/rtl/rfps_ram.sv
// ---------------------------------------------------------------------------
// rfps_ram - generic RAM
// One write port and one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rfps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/rfps_ctrl.sv
// ---------------------------------------------------------------------------
// rfps_ctrl - selector controller
// Sequences the clearing pass, updates, the piece scan and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module rfps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rfps_pkg::t_ctl_sts i_sts,
    output rfps_pkg::t_ctl_cmd     o_cmd
);
    import rfps_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;
    logic   accept;

    assign accept = i_in_valid && !r_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = accept;
                if (accept) begin
                    if (i_sts.is_ram_upd) begin
                        n_state = S_UPD;
                    end else if (i_sts.is_query) begin
                        n_state = i_sts.q_ok ? S_SCAN : S_FIN;
                    end
                end
            end
            S_UPD: begin
                o_cmd.upd_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

`default_nettype wire

### hw/rtl/rfps_datapath.sv
// ---------------------------------------------------------------------------
// rfps_datapath - selector datapath
// Peer ready flags, config registers, piece RAM with read-modify-write,
// three-stage scan pipe (read, count, compare) and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rfps_datapath #(
    parameter int MAX_PEER_SLOTS  = 16,
    parameter int MAX_PIECE_COUNT = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rfps_pkg::t_ctl_cmd i_cmd,
    output rfps_pkg::t_ctl_sts      o_sts,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [3:0]         i_peer,
    input  wire logic [9:0]         i_piece,
    input  wire logic [1:0]         i_new_value,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [10:0]        i_cfg_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_found,
    output logic [9:0]              o_piece_index,
    output logic [4:0]              o_availability
);
    import rfps_pkg::*;

    localparam int P  = MAX_PEER_SLOTS;
    localparam int PW = $clog2(MAX_PIECE_COUNT + 1);
    localparam int AW = (MAX_PIECE_COUNT > 1) ? $clog2(MAX_PIECE_COUNT) : 1;
    localparam int CW = $clog2(MAX_PEER_SLOTS + 1);
    localparam int DW = MAX_PEER_SLOTS + 2;

    // config and peer flags
    logic [10:0]   r_total_pieces;
    logic [4:0]    r_peers_in_use;
    logic [P-1:0]  r_ready;

    // latched request
    logic [PW-1:0] r_addr;
    logic [PW-1:0] r_npieces;
    logic [P-1:0]  r_ready_mask;
    logic [P-1:0]  r_peer_mask;
    t_req_type     r_upd_kind;
    logic          r_upd_ok;
    logic [1:0]    r_upd_val;
    logic [AW-1:0] r_upd_addr;

    // scan pipe
    logic          r_s1_vld;
    logic [AW-1:0] r_s1_idx;
    logic          r_s2_vld;
    logic          r_s2_elig;
    logic [CW-1:0] r_s2_cnt;
    logic [AW-1:0] r_s2_idx;
    logic          r_best_have;
    logic [CW-1:0] r_best_cnt;
    logic [AW-1:0] r_best_idx;

    // result register
    logic          r_out_valid;
    logic          r_found;
    logic [9:0]    r_pidx;
    logic [4:0]    r_avail;

    t_req_type     req_kind;
    logic [P-1:0]  peer_onehot;
    logic [P-1:0]  inuse_mask;
    logic [PW-1:0] npieces_now;
    logic          piece_ok;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;
    logic [P-1:0]  rd_holders;
    logic [1:0]    rd_state;
    logic [P-1:0]  upd_holders;
    logic [1:0]    upd_state;
    logic [P-1:0]  cnt_bits;
    logic [CW-1:0] cnt;
    logic          elig;
    logic          better;
    logic          out_taken;

    assign req_kind = t_req_type'(i_req_type);
    assign piece_ok = (int'(i_piece) < MAX_PIECE_COUNT);

    always_comb begin
        for (int i = 0; i < P; i++) begin
            peer_onehot[i] = (int'(i_peer) == i);
            inuse_mask[i]  = (i < int'(r_peers_in_use));
        end
    end

    assign npieces_now = (int'(r_total_pieces) > MAX_PIECE_COUNT) ?
                         PW'(MAX_PIECE_COUNT) : PW'(r_total_pieces);

    // status
    always_comb begin
        o_sts            = '0;
        o_sts.is_query   = (req_kind == REQ_QUERY);
        o_sts.is_ram_upd = (req_kind == REQ_SET_HAVE) || (req_kind == REQ_SET_STATUS);
        o_sts.q_ok       = (|(peer_onehot & r_ready & inuse_mask)) && (npieces_now != '0);
        o_sts.scan_last  = ((r_addr + PW'(1)) == r_npieces);
        o_sts.clr_last   = (r_addr == PW'(MAX_PIECE_COUNT - 1));
        o_sts.pipe_busy  = r_s1_vld || r_s2_vld;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // piece RAM: {status, holder mask}
    assign rd_holders = ram_rdata[P-1:0];
    assign rd_state   = ram_rdata[DW-1 -: 2];

    always_comb begin
        upd_holders = rd_holders;
        upd_state   = rd_state;
        if (r_upd_kind == REQ_SET_HAVE) begin
            upd_holders = (r_upd_val != 2'd0) ? (rd_holders | r_peer_mask)
                                              : (rd_holders & ~r_peer_mask);
        end else begin
            upd_state = r_upd_val;
        end
    end

    assign ram_we    = i_cmd.clr_wr || (i_cmd.upd_wr && r_upd_ok);
    assign ram_waddr = i_cmd.clr_wr ? r_addr[AW-1:0] : r_upd_addr;
    assign ram_wdata = i_cmd.clr_wr ? {ST_FREE, {P{1'b0}}} : {upd_state, upd_holders};
    assign ram_re    = i_cmd.accept || i_cmd.scan_issue;
    assign ram_raddr = i_cmd.scan_issue ? r_addr[AW-1:0] : AW'(i_piece);

    rfps_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_PIECE_COUNT)
    ) u_piece_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // count stage
    assign cnt_bits = rd_holders & r_ready_mask;
    assign elig     = (rd_state == ST_FREE) && (|(rd_holders & r_peer_mask));

    always_comb begin
        cnt = '0;
        for (int i = 0; i < P; i++) begin
            cnt = cnt + CW'(cnt_bits[i]);
        end
    end

    // strict less-than keeps the lowest index on ties
    assign better    = r_s2_vld && r_s2_elig && (!r_best_have || (r_s2_cnt < r_best_cnt));
    assign out_taken = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pieces <= TOTAL_PIECES_RST;
            r_peers_in_use <= PEERS_IN_USE_RST;
            r_ready        <= '0;
            r_addr         <= '0;
            r_s1_vld       <= 1'b0;
            r_s2_vld       <= 1'b0;
            r_best_have    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TOTAL_PIECES) begin
                    r_total_pieces <= i_cfg_data;
                end else begin
                    r_peers_in_use <= i_cfg_data[4:0];
                end
            end

            if (i_cmd.accept && req_kind == REQ_SET_READY) begin
                r_ready <= (i_new_value != 2'd0) ? (r_ready | peer_onehot)
                                                 : (r_ready & ~peer_onehot);
            end

            if (i_cmd.accept) begin
                r_addr <= '0;
            end else if (i_cmd.clr_wr || i_cmd.scan_issue) begin
                r_addr <= r_addr + PW'(1);
            end

            r_s1_vld <= i_cmd.scan_issue;
            r_s2_vld <= r_s1_vld;

            if (i_cmd.accept) begin
                r_best_have <= 1'b0;
            end else if (better) begin
                r_best_have <= 1'b1;
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_npieces    <= npieces_now;
            r_ready_mask <= r_ready & inuse_mask;
            r_peer_mask  <= peer_onehot;
            r_upd_kind   <= req_kind;
            r_upd_val    <= i_new_value;
            r_upd_addr   <= AW'(i_piece);
            r_upd_ok     <= piece_ok && ((req_kind != REQ_SET_HAVE) || (|peer_onehot));
        end
        r_s1_idx  <= r_addr[AW-1:0];
        r_s2_idx  <= r_s1_idx;
        r_s2_elig <= elig;
        r_s2_cnt  <= cnt;
        if (better) begin
            r_best_cnt <= r_s2_cnt;
            r_best_idx <= r_s2_idx;
        end
        if (i_cmd.load_out) begin
            r_found <= r_best_have;
            r_pidx  <= r_best_have ? 10'(r_best_idx) : 10'd0;
            r_avail <= r_best_have ? 5'(r_best_cnt) : 5'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_piece_index  = r_pidx;
    assign o_availability = r_avail;

    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a stalled word");

    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_issue || r_s1_vld || r_s2_vld) |-> !ram_we)
        else $error("piece RAM written during scan");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_pidx == 10'd0 && r_avail == 5'd0))
        else $error("not-found result carries nonzero fields");

    a_best_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_have |-> (r_best_cnt <= CW'(MAX_PEER_SLOTS)))
        else $error("best availability exceeds peer slots");

endmodule

`default_nettype wire

### hw/rtl/rarest_first_piece_selector.sv
// Updates: a ready flag is written on accept; a have-bit/status update reads the
//   piece entry, then writes it back. A query scans npieces = pieces in use
//   entries via read, count and compare; a bad peer or zero pieces skips the scan.
//   Input stalls until the result is loaded, which a stalled output holds off.
// Reset: synchronous, active low; afterwards a clearing pass writes every
//   piece entry with input stalled; config is open.
// ---------------------------------------------------------------------------
// rarest_first_piece_selector - top level
// Keeps peer ready flags, per-piece holder masks and status, and answers
// queries with the free piece of the named peer held by the fewest peers.
// ---------------------------------------------------------------------------
`default_nettype none

module rarest_first_piece_selector #(
    parameter int MAX_PEER_SLOTS  = 16,
    parameter int MAX_PIECE_COUNT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [3:0]  i_peer,
    input  wire logic [9:0]  i_piece,
    input  wire logic [1:0]  i_new_value,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [10:0] i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_found,
    output logic [9:0]       o_piece_index,
    output logic [4:0]       o_availability
);
    import rfps_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    rfps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rfps_datapath #(
        .MAX_PEER_SLOTS  (MAX_PEER_SLOTS),
        .MAX_PIECE_COUNT (MAX_PIECE_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req_type),
        .i_peer         (i_peer),
        .i_piece        (i_piece),
        .i_new_value    (i_new_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_piece_index  (o_piece_index),
        .o_availability (o_availability)
    );

endmodule

`default_nettype wire
